FILE: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL. They expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/mses_pkg.sv
`timescale 1ns / 1ps

package mses_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned PwordsW  = 17;
  localparam int unsigned RegCount = 32;

  // Major opcodes.
  localparam logic [5:0] OpRtype = 6'h00;
  localparam logic [5:0] OpBeq   = 6'h04;
  localparam logic [5:0] OpBne   = 6'h05;
  localparam logic [5:0] OpAddi  = 6'h08;

  // R-type function codes.
  localparam logic [5:0] FnSll = 6'd0;
  localparam logic [5:0] FnSrl = 6'd2;
  localparam logic [5:0] FnSra = 6'd3;
  localparam logic [5:0] FnAdd = 6'd32;
  localparam logic [5:0] FnAnd = 6'd36;
  localparam logic [5:0] FnOr  = 6'd37;
  localparam logic [5:0] FnSlt = 6'd42;

  typedef struct packed {
    logic               wr;
    logic [RegIdxW-1:0] widx;
    logic [DataW-1:0]   wval;
    logic               unknown;
    logic [DataW-1:0]   pc_next;
  } exec_t;

endpackage

FILE: rtl/mses_ram.sv
`timescale 1ns / 1ps

module mses_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mses_regfile.sv
`timescale 1ns / 1ps

module mses_regfile #(
  parameter int unsigned RegCount = mses_pkg::RegCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [mses_pkg::RegIdxW-1:0] rs_addr_i,
  input  logic [mses_pkg::RegIdxW-1:0] rt_addr_i,
  input  logic [mses_pkg::RegIdxW-1:0] insp_addr_i,
  input  logic                         wr_en_i,
  input  logic [mses_pkg::RegIdxW-1:0] wr_addr_i,
  input  logic [mses_pkg::DataW-1:0]   wr_data_i,
  output logic [mses_pkg::DataW-1:0]   rs_data_o,
  output logic [mses_pkg::DataW-1:0]   rt_data_o,
  output logic [mses_pkg::DataW-1:0]   insp_data_o
);

  localparam int unsigned AddrW = $clog2(RegCount);
  localparam int unsigned NumRd = 3;

  logic [NumRd-1:0][mses_pkg::RegIdxW-1:0] rd_addr;
  logic [NumRd-1:0][mses_pkg::RegIdxW-1:0] rd_addr_q;
  logic [NumRd-1:0]                        rd_live_q;
  logic [NumRd-1:0][mses_pkg::DataW-1:0]   ram_data;
  logic [NumRd-1:0][mses_pkg::DataW-1:0]   rd_data;

  // An entry that was never written reads as zero.
  logic [RegCount-1:0] vld_q;

  // Last write, for a read issued at the same edge as that write.
  logic                         fwd_vld_q;
  logic [mses_pkg::RegIdxW-1:0] fwd_addr_q;
  logic [mses_pkg::DataW-1:0]   fwd_data_q;

  assign rd_addr[0] = rs_addr_i;
  assign rd_addr[1] = rt_addr_i;
  assign rd_addr[2] = insp_addr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i[AddrW-1:0]] <= 1'b1;
      fwd_vld_q                   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_addr_q <= wr_addr_i;
      fwd_data_q <= wr_data_i;
    end
  end

  for (genvar p = 0; p < NumRd; p++) begin : g_port
    logic in_range;
    logic fwd_hit;

    assign in_range = {1'b0, rd_addr[p]} < (mses_pkg::RegIdxW + 1)'(RegCount);

    mses_ram #(
      .Width(mses_pkg::DataW),
      .Depth(RegCount)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en_i),
      .waddr_i(wr_addr_i[AddrW-1:0]),
      .wdata_i(wr_data_i),
      .re_i   (rd_en_i),
      .raddr_i(rd_addr[p][AddrW-1:0]),
      .rdata_o(ram_data[p])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rd_live_q[p] <= 1'b0;
      end else if (rd_en_i) begin
        rd_live_q[p] <= in_range && vld_q[rd_addr[p][AddrW-1:0]];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_addr_q[p] <= rd_addr[p];
      end
    end

    assign fwd_hit    = fwd_vld_q && (fwd_addr_q == rd_addr_q[p]);
    assign rd_data[p] = fwd_hit      ? fwd_data_q :
                        rd_live_q[p] ? ram_data[p] : '0;
  end

  assign rs_data_o   = rd_data[0];
  assign rt_data_o   = rd_data[1];
  assign insp_data_o = rd_data[2];

endmodule

FILE: rtl/mses_alu.sv
`timescale 1ns / 1ps

module mses_alu (
  input  logic [mses_pkg::DataW-1:0] instr_i,
  input  logic [mses_pkg::DataW-1:0] a_i,
  input  logic [mses_pkg::DataW-1:0] b_i,
  input  logic [mses_pkg::DataW-1:0] pc_i,
  output mses_pkg::exec_t            exe_o
);

  logic [5:0]                   op;
  logic [5:0]                   funct;
  logic [mses_pkg::RegIdxW-1:0] rt;
  logic [mses_pkg::RegIdxW-1:0] rd;
  logic [4:0]                   sa;
  logic [mses_pkg::DataW-1:0]   simm;
  logic [mses_pkg::DataW-1:0]   pc4;
  logic [mses_pkg::DataW-1:0]   target;

  assign op     = instr_i[31:26];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sa     = instr_i[10:6];
  assign funct  = instr_i[5:0];
  assign simm   = {{16{instr_i[15]}}, instr_i[15:0]};
  assign pc4    = pc_i + 32'd4;
  assign target = pc4 + {simm[29:0], 2'b00};

  always_comb begin
    exe_o         = '0;
    exe_o.pc_next = pc4;
    case (op)
      mses_pkg::OpAddi: begin
        exe_o.wr   = 1'b1;
        exe_o.widx = rt;
        exe_o.wval = a_i + simm;
      end
      mses_pkg::OpBeq: begin
        if (a_i == b_i) begin
          exe_o.pc_next = target;
        end
      end
      mses_pkg::OpBne: begin
        if (a_i != b_i) begin
          exe_o.pc_next = target;
        end
      end
      mses_pkg::OpRtype: begin
        exe_o.wr   = 1'b1;
        exe_o.widx = rd;
        case (funct)
          mses_pkg::FnAdd: exe_o.wval = a_i + b_i;
          mses_pkg::FnAnd: exe_o.wval = a_i & b_i;
          mses_pkg::FnOr:  exe_o.wval = a_i | b_i;
          mses_pkg::FnSll: exe_o.wval = b_i << sa;
          mses_pkg::FnSrl: exe_o.wval = b_i >> sa;
          mses_pkg::FnSra: exe_o.wval = $unsigned($signed(b_i) >>> sa);
          mses_pkg::FnSlt: exe_o.wval = {31'd0, $signed(a_i) < $signed(b_i)};
          default: begin
            exe_o.wr      = 1'b0;
            exe_o.unknown = 1'b1;
          end
        endcase
      end
      default: begin
        exe_o.unknown = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/mips_subset_execute_step.sv
// Executes one instruction of a small MIPS32 subset per request.
// Input channel: in_valid_i/in_ready_o carry an instruction word and the
// number of a register to report. Output channel: out_valid_o/out_ready_i
// carry the next PC, the register write made, the unknown and halted flags,
// and the value of the reported register after the step.
// The register file lives in synchronous RAMs (one copy per read port) and
// is read when a request is accepted; the execute stage uses the registered
// read data and writes back at the edge where its result is registered.
// A request waits in the execute stage until the output register is free or
// being taken, and its result is then registered there for the receiver.
// Throughput: one request per cycle while the receiver does not stall; the PC
// update and the write-back to the register file close in the execute stage,
// with the last write forwarded to the read that starts at the same edge.
// The user must write program_words through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Reset clears the PC, program_words and the per-register valid bits, so
// every register reads zero at once; there is no clearing pass.
// When the receiver stalls, the output register holds its result, the
// execute stage holds the next request, and in_ready_o drops only when
// both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_subset_execute_step #(
  parameter int unsigned RegCount = mses_pkg::RegCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mses_pkg::PwordsW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mses_pkg::DataW-1:0]   instruction_i,
  input  logic [mses_pkg::RegIdxW-1:0] inspect_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mses_pkg::DataW-1:0]   pc_next_o,
  output logic                         reg_written_o,
  output logic [mses_pkg::RegIdxW-1:0] dest_index_o,
  output logic [mses_pkg::DataW-1:0]   dest_value_o,
  output logic                         unknown_op_o,
  output logic                         halted_o,
  output logic [mses_pkg::DataW-1:0]   inspect_value_o
);

  logic [mses_pkg::PwordsW-1:0] pwords_q;
  logic [mses_pkg::DataW-1:0]   pc_q, pc_d;

  logic                         s1_valid_q;
  logic [mses_pkg::DataW-1:0]   s1_instr_q;
  logic [mses_pkg::RegIdxW-1:0] s1_insp_q;
  logic                         s1_fire;
  logic                         accept;

  logic [mses_pkg::DataW-1:0]   rs_data, rt_data, insp_data;
  mses_pkg::exec_t              exe;
  logic                         halt;
  logic                         written;
  logic [mses_pkg::DataW-1:0]   insp_val;

  logic                         out_valid_q;
  logic [mses_pkg::DataW-1:0]   out_pc_q;
  logic                         out_written_q;
  logic [mses_pkg::RegIdxW-1:0] out_didx_q;
  logic [mses_pkg::DataW-1:0]   out_dval_q;
  logic                         out_unknown_q;
  logic                         out_halted_q;
  logic [mses_pkg::DataW-1:0]   out_insp_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwords_q <= '0;
    end else if (cfg_we_i) begin
      pwords_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_instr_q <= instruction_i;
      s1_insp_q  <= inspect_index_i;
    end
  end

  mses_regfile #(
    .RegCount(RegCount)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rs_addr_i  (instruction_i[25:21]),
    .rt_addr_i  (instruction_i[20:16]),
    .insp_addr_i(inspect_index_i),
    .wr_en_i    (s1_fire && written),
    .wr_addr_i  (exe.widx),
    .wr_data_i  (exe.wval),
    .rs_data_o  (rs_data),
    .rt_data_o  (rt_data),
    .insp_data_o(insp_data)
  );

  mses_alu u_alu (
    .instr_i(s1_instr_q),
    .a_i    (rs_data),
    .b_i    (rt_data),
    .pc_i   (pc_q),
    .exe_o  (exe)
  );

  // Past the loaded program the step is dropped and the PC stays put.
  assign halt    = pc_q >= mses_pkg::DataW'({pwords_q, 2'b00});
  assign written = !halt && exe.wr && (exe.widx != '0) &&
                   ({1'b0, exe.widx} < (mses_pkg::RegIdxW + 1)'(RegCount));
  assign pc_d    = halt ? pc_q : exe.pc_next;

  // The reported register sees this step's own write.
  assign insp_val = (written && (s1_insp_q == exe.widx)) ? exe.wval : insp_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_fire) begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pc_q      <= pc_d;
      out_written_q <= written;
      out_didx_q    <= written ? exe.widx : '0;
      out_dval_q    <= written ? exe.wval : '0;
      out_unknown_q <= !halt && exe.unknown;
      out_halted_q  <= halt;
      out_insp_q    <= insp_val;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pc_next_o       = out_pc_q;
  assign reg_written_o   = out_written_q;
  assign dest_index_o    = out_didx_q;
  assign dest_value_o    = out_dval_q;
  assign unknown_op_o    = out_unknown_q;
  assign halted_o        = out_halted_q;
  assign inspect_value_o = out_insp_q;

  `ASSERT_CLK(a_halt_quiet, out_valid_o && halted_o |-> !reg_written_o && !unknown_op_o, "halted step reported activity")
  `ASSERT_CLK(a_s1_hold, s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_instr_q), "execute stage lost a stalled request")
  `ASSERT_CLK(a_no_r0_write, s1_fire && written |-> exe.widx != '0, "write to register zero")
  `ASSERT_CLK(a_pc_halt, s1_fire && halt |=> pc_q == $past(pc_q), "PC moved on a halted step")

endmodule
